>>> src/infix_to_postfix_converter_defines.svh
// Assertion macros for the infix-to-postfix converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// property checked every cycle outside reset
`define I2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies an expression in the next cycle
`define I2P_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

>>> src/i2p_pkg.sv
// Shared constants, types and the precedence function of the converter.
// No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CLOSE    = 2'd2;
  localparam logic [1:0] ERR_OPEN     = 2'd3;

  localparam logic [1:0] RANK_OPEN = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  typedef struct packed {
    logic is_open;
    logic pop;
  } cmp_res_t;

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    logic [1:0] r;
    r = RANK_OPEN;
    case (c) inside
      CH_ADD, CH_SUB: r = RANK_ADD;
      CH_MUL, CH_DIV: r = RANK_MUL;
      default:        r = RANK_OPEN;
    endcase
    return r;
  endfunction

endpackage

>>> src/i2p_stack.sv
// Operator stack storage: single write port, registered read port.
// Depends on nothing but its parameter.
module i2p_stack #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/i2p_rank_cmp.sv
// Precedence compare unit, used once per popped stack entry.
// Depends on i2p_pkg.
module i2p_rank_cmp
  import i2p_pkg::*;
(
  input  logic [7:0] top_char,
  input  logic [1:0] in_rank,
  output cmp_res_t   res
);

  logic [1:0] top_rank;

  assign top_rank    = op_rank(top_char);
  assign res.is_open = (top_char == CH_OPEN);
  assign res.pop     = (top_char != CH_OPEN) && (top_rank >= in_rank);

endmodule

>>> src/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter: sequencer,
// result hold stage and output register. Depends on i2p_pkg, i2p_stack,
// i2p_rank_cmp and infix_to_postfix_converter_defines.svh.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  in       | in_valid / in_stall | in_char, in_end_of_expr
//  out      | out_valid/out_stall | out_char, out_char_valid, out_is_last,
//           |                     | out_error_code
//
// Operand: TAIL. '(': PUSH, TAIL. ')': RD and CHK per popped entry, then TAIL.
// Operator: RD and CHK per popped entry, then PUSH and TAIL; the stack RAM's
// registered read sets the pop pace. End flushes via RD and CHK, then LAST.
// Every result passes a one-deep hold stage so that the final one can be
// marked last; a stalled output holds the sequencer until the register frees.
// Synchronous reset empties the stack and clears the error; no clearing pass.
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end_of_expr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_is_last,
  output logic [1:0] out_error_code
);

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CHK  = 6'b000100,
    S_PUSH = 6'b001000,
    S_TAIL = 6'b010000,
    S_LAST = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    MODE_OP    = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_END   = 2'd2
  } mode_t;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             end_r, end_nxt;
  logic [1:0]       rank_r, rank_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_char_r, pend_char_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_cv_r, out_cv_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_err_r, out_err_nxt;

  logic             out_free;
  logic             can_emit;
  logic             emit_req;
  logic [7:0]       emit_ch;
  logic             wr_en, rd_en;
  logic [7:0]       rd_data;
  logic [LVL_W-1:0] level_m1;
  logic             stack_full;
  cmp_res_t         cmp;

  assign level_m1   = level_r - LVL_W'(1);
  assign stack_full = (level_r == LVL_W'(STACK_DEPTH));
  assign out_free   = !out_valid_r || !out_stall;
  assign can_emit   = !pend_v_r || out_free;

  i2p_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (level_r[ADDR_W-1:0]),
    .wr_data (char_r),
    .rd_en   (rd_en),
    .rd_addr (level_m1[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  i2p_rank_cmp u_cmp (
    .top_char (rd_data),
    .in_rank  (rank_r),
    .res      (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    char_nxt      = char_r;
    end_nxt       = end_r;
    rank_nxt      = rank_r;
    level_nxt     = level_r;
    err_nxt       = err_r;
    pend_v_nxt    = pend_v_r;
    pend_char_nxt = pend_char_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    emit_req      = 1'b0;
    emit_ch       = rd_data;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt = in_char;
          end_nxt  = in_end_of_expr;
          rank_nxt = op_rank(in_char);
          case (in_char) inside
            CH_OPEN: begin
              state_nxt = S_PUSH;
            end
            CH_ADD, CH_SUB, CH_MUL, CH_DIV: begin
              mode_nxt  = MODE_OP;
              state_nxt = S_RD;
            end
            CH_CLOSE: begin
              mode_nxt  = MODE_CLOSE;
              state_nxt = S_RD;
            end
            default: begin
              pend_v_nxt    = 1'b1;
              pend_char_nxt = in_char;
              state_nxt     = S_TAIL;
            end
          endcase
        end
      end
      S_RD: begin
        if (level_r == '0) begin
          unique case (mode_r)
            MODE_OP:    state_nxt = S_PUSH;
            MODE_CLOSE: begin
              if (err_r == ERR_NONE) err_nxt = ERR_CLOSE;
              state_nxt = S_TAIL;
            end
            MODE_END:   state_nxt = S_LAST;
            default:    state_nxt = S_LAST;
          endcase
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        unique case (mode_r)
          MODE_OP: begin
            if (!cmp.pop) begin
              state_nxt = S_PUSH;
            end else if (can_emit) begin
              emit_req  = 1'b1;
              level_nxt = level_m1;
              state_nxt = S_RD;
            end
          end
          MODE_CLOSE: begin
            if (cmp.is_open) begin
              level_nxt = level_m1;
              state_nxt = S_TAIL;
            end else if (can_emit) begin
              emit_req  = 1'b1;
              level_nxt = level_m1;
              state_nxt = S_RD;
            end
          end
          default: begin
            if (cmp.is_open) begin
              if (err_r == ERR_NONE) err_nxt = ERR_OPEN;
              level_nxt = level_m1;
              state_nxt = S_RD;
            end else if (can_emit) begin
              emit_req  = 1'b1;
              level_nxt = level_m1;
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (!stack_full) begin
          wr_en     = 1'b1;
          level_nxt = level_r + LVL_W'(1);
        end else if (err_r == ERR_NONE) begin
          err_nxt = ERR_OVERFLOW;
        end
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (end_r) begin
          mode_nxt  = MODE_END;
          state_nxt = S_RD;
        end else if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_char_r;
          out_cv_nxt    = 1'b1;
          out_last_nxt  = 1'b0;
          out_err_nxt   = ERR_NONE;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_LAST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_v_r ? pend_char_r : 8'h00;
          out_cv_nxt    = pend_v_r;
          out_last_nxt  = 1'b1;
          out_err_nxt   = err_r;
          pend_v_nxt    = 1'b0;
          err_nxt       = ERR_NONE;
          level_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // hold stage: an older held result moves on when a new one arrives
    if (emit_req) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = pend_char_r;
        out_cv_nxt    = 1'b1;
        out_last_nxt  = 1'b0;
        out_err_nxt   = ERR_NONE;
      end
      pend_v_nxt    = 1'b1;
      pend_char_nxt = emit_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_OP;
      level_r     <= '0;
      err_r       <= ERR_NONE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      level_r     <= level_nxt;
      err_r       <= err_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    end_r       <= end_nxt;
    rank_r      <= rank_nxt;
    pend_char_r <= pend_char_nxt;
    out_char_r  <= out_char_nxt;
    out_cv_r    <= out_cv_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_is_last    = out_last_r;
  assign out_error_code = out_err_r;

  `I2P_ASSERT(a_level_bound, level_r <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
  `I2P_ASSERT(a_err_only_last, (out_valid_r && !out_last_r) |-> (out_err_r == ERR_NONE), "error code on non-last item")
  `I2P_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_r != S_IDLE, "accepted item not processed")
  `I2P_ASSERT_NEXT(a_err_sticky, (err_r != ERR_NONE) && (state_r != S_LAST), $stable(err_r), "error code changed mid expression")

endmodule

>>> test/infix_to_postfix_converter_tb.sv
// Testbench for infix_to_postfix_converter: directed and random expressions are
// driven through the input channel and every postfix item is checked against a
// built-in shunting-yard predictor. Depends on i2p_pkg and the converter RTL.
module infix_to_postfix_converter_tb
  import i2p_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] chr;
    logic       eoe;
  } infix_item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       chr_ok;
    logic       is_last;
    logic [1:0] err;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_is_last;
  logic [1:0] out_error_code;

  infix_item_t infix_q[$];
  postfix_t    postfix_q[$];
  infix_item_t next_item;
  postfix_t    want_res;

  logic [7:0] opstk[STACK_DEPTH_DEF];
  int         op_level = 0;
  logic [1:0] op_err = ERR_NONE;

  int infix_taken = 0;
  int items_made = 0;
  int mismatches = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_cycles = 0;
  int mode_left = 0;
  int stall_mode = 0;
  bit long_hold_done = 1'b0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char(in_char),
    .in_end_of_expr(in_end_of_expr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .out_char_valid(out_char_valid),
    .out_is_last(out_is_last),
    .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  function automatic int prec_of(input logic [7:0] c);
    case (c)
      CH_OPEN:        return 0;
      CH_ADD, CH_SUB: return 1;
      CH_MUL, CH_DIV: return 2;
      default:        return -1;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'($urandom_range(97, 122));
      1: c = 8'($urandom_range(48, 57));
      2: c = 8'h20;
      default: begin
        c = 8'($urandom_range(0, 255));
        if (prec_of(c) >= 0 || c == CH_CLOSE) c = 8'h7E;
      end
    endcase
    return c;
  endfunction

  task automatic flag_error(input logic [1:0] code);
    if (op_err == ERR_NONE) op_err = code;
  endtask

  task automatic push_op(input logic [7:0] c);
    if (op_level < STACK_DEPTH_DEF) begin
      opstk[op_level] = c;
      op_level++;
    end else begin
      flag_error(ERR_OVERFLOW);
    end
  endtask

  // expected postfix items for one accepted infix character
  task automatic shunt_char(input logic [7:0] c, input logic eoe);
    postfix_t   res[$];
    logic [7:0] top;
    logic       matched;
    int         r;
    r = prec_of(c);
    if (c == CH_OPEN) begin
      push_op(c);
    end else if (r > 0) begin
      while (op_level > 0 && opstk[op_level-1] != CH_OPEN
             && prec_of(opstk[op_level-1]) >= r) begin
        res.push_back('{chr: opstk[op_level-1], chr_ok: 1'b1, is_last: 1'b0, err: ERR_NONE});
        op_level--;
      end
      push_op(c);
    end else if (c == CH_CLOSE) begin
      matched = 1'b0;
      while (op_level > 0 && !matched) begin
        top = opstk[op_level-1];
        op_level--;
        if (top == CH_OPEN) matched = 1'b1;
        else res.push_back('{chr: top, chr_ok: 1'b1, is_last: 1'b0, err: ERR_NONE});
      end
      if (!matched) flag_error(ERR_CLOSE);
    end else begin
      res.push_back('{chr: c, chr_ok: 1'b1, is_last: 1'b0, err: ERR_NONE});
    end
    if (eoe) begin
      while (op_level > 0) begin
        top = opstk[op_level-1];
        op_level--;
        if (top == CH_OPEN) flag_error(ERR_OPEN);
        else res.push_back('{chr: top, chr_ok: 1'b1, is_last: 1'b0, err: ERR_NONE});
      end
      if (res.size() == 0)
        res.push_back('{chr: 8'h00, chr_ok: 1'b0, is_last: 1'b0, err: ERR_NONE});
      res[res.size()-1].is_last = 1'b1;
      res[res.size()-1].err = op_err;
      op_level = 0;
      op_err = ERR_NONE;
    end
    foreach (res[i]) postfix_q.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic add_char(input logic [7:0] c, input logic eoe);
    infix_q.push_back('{chr: c, eoe: eoe});
    items_made++;
  endtask

  // mostly balanced expression; broken ones leave opens, add closes or end on an operator
  task automatic gen_expression(input bit broken);
    int terms;
    int opens;
    terms = $urandom_range(1, 8);
    opens = 0;
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_char(pick_op(), 1'b0);
      while ($urandom_range(0, 3) == 0 && opens < 6) begin
        add_char(CH_OPEN, 1'b0);
        opens++;
      end
      add_char(pick_operand(), 1'b0);
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CH_CLOSE, 1'b0);
        opens--;
      end
    end
    if (!broken) begin
      while (opens > 0) begin
        add_char(CH_CLOSE, 1'b0);
        opens--;
      end
    end else begin
      case ($urandom_range(0, 2))
        0: ;
        1: for (int i = 0; i <= opens; i++) add_char(CH_CLOSE, 1'b0);
        default: add_char(pick_op(), 1'b0);
      endcase
    end
    infix_q[infix_q.size()-1].eoe = 1'b1;
  endtask

  task automatic gen_random(input int upto);
    int pick;
    while (items_made < upto) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        gen_expression(1'b0);
      end else if (pick == 7) begin
        gen_expression(1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)),
                                               $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (infix_q.size() != 0 || in_valid || postfix_q.size() != 0) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shunt_char(in_char, in_end_of_expr);
        infix_taken <= infix_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || infix_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_item = infix_q.pop_front();
          in_valid <= 1'b1;
          in_char <= next_item.chr;
          in_end_of_expr <= next_item.eoe;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // receiver stall: changing modes, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!long_hold_done && infix_taken >= 70) begin
      long_hold_done <= 1'b1;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (postfix_q.size() == 0) begin
        report_mismatch("unexpected item", out_char, 8'h00);
      end else begin
        want_res = postfix_q.pop_front();
        if (out_char !== want_res.chr) report_mismatch("char", out_char, want_res.chr);
        if (out_char_valid !== want_res.chr_ok)
          report_mismatch("char_valid", 8'(out_char_valid), 8'(want_res.chr_ok));
        if (out_is_last !== want_res.is_last)
          report_mismatch("is_last", 8'(out_is_last), 8'(want_res.is_last));
        if (out_error_code !== want_res.err)
          report_mismatch("error_code", 8'(out_error_code), 8'(want_res.err));
      end
    end
  end

  initial begin
    // all operators, left associativity at both levels
    add_char("a", 1'b0); add_char(CH_SUB, 1'b0); add_char("b", 1'b0);
    add_char(CH_ADD, 1'b0); add_char("c", 1'b0); add_char(CH_MUL, 1'b0);
    add_char("d", 1'b0); add_char(CH_DIV, 1'b0); add_char("e", 1'b1);
    // extreme operand bytes inside parentheses
    add_char(CH_OPEN, 1'b0); add_char(8'h00, 1'b0); add_char(CH_SUB, 1'b0);
    add_char(8'hFF, 1'b0); add_char(CH_CLOSE, 1'b0); add_char(CH_DIV, 1'b0);
    add_char("z", 1'b1);
    // stray close empties the stack
    add_char("a", 1'b0); add_char(CH_ADD, 1'b0); add_char("b", 1'b0);
    add_char(CH_CLOSE, 1'b1);
    // opens left at end
    add_char(CH_OPEN, 1'b0); add_char(CH_OPEN, 1'b0); add_char("a", 1'b1);
    // nothing to show at end
    add_char(CH_OPEN, 1'b1);
    // operator as the last character
    add_char(CH_MUL, 1'b1);
    // first error sticks
    add_char(CH_CLOSE, 1'b0); add_char(CH_OPEN, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // full stack: one open too many, then an operator that cannot be pushed
    repeat (STACK_DEPTH_DEF + 1) add_char(CH_OPEN, 1'b0);
    add_char(CH_ADD, 1'b0);
    add_char("k", 1'b1);
    gen_random(135);
    wait_drained();

    gen_random(230);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
